FILE: rtl/core/bfsa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the best-fit segment allocator
// no dependencies

package bfsa_pkg;

    localparam int NODES       = 64;
    localparam int ARENA_BYTES = 65535;
    localparam int IDX_W       = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W       = $clog2(NODES + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NO_BLOCK = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // one segment of the list, held in list order along the chain
    typedef struct packed {
        logic             valid;
        logic             hole;
        logic [15:0]      size;
        logic [15:0]      start;
        logic [IDX_W-1:0] slot;
    } seg_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_EXACT,
        OP_SPLIT,
        OP_FREE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] pos;
        seg_t             new_seg;
        seg_t             hole_seg;
    } cmd_t;

endpackage

FILE: rtl/core/bfsa_cell.sv
`timescale 1ns / 1ps
// one cell of the segment chain: holds the segment at one list position
// depends on bfsa_pkg

module bfsa_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bfsa_pkg::IDX_W-1:0] idx,
    input  bfsa_pkg::cmd_t            cmd,
    input  bfsa_pkg::seg_t            left_seg,
    input  bfsa_pkg::seg_t            right_seg,
    output bfsa_pkg::seg_t            seg
);

    bfsa_pkg::seg_t seg_reg;
    bfsa_pkg::seg_t seg_next;
    logic           at_pos;
    logic           at_next;
    logic           past_next;
    logic [bfsa_pkg::IDX_W:0] pos_plus;
    logic [bfsa_pkg::IDX_W:0] idx_w;

    assign idx_w     = {1'b0, idx};
    assign pos_plus  = {1'b0, cmd.pos} + 1'b1;
    assign at_pos    = (idx == cmd.pos);
    assign at_next   = (idx_w == pos_plus);
    assign past_next = (idx_w > pos_plus);

    always_comb
    begin
        seg_next = seg_reg;
        case (cmd.op)
            bfsa_pkg::OP_HOLD:
            begin
                seg_next = seg_reg;
            end
            bfsa_pkg::OP_ROT:
            begin
                seg_next = right_seg;
            end
            bfsa_pkg::OP_EXACT:
            begin
                if (at_pos)
                begin
                    seg_next.hole = 1'b0;
                end
            end
            bfsa_pkg::OP_FREE:
            begin
                if (at_pos)
                begin
                    seg_next.hole = 1'b1;
                end
            end
            bfsa_pkg::OP_SPLIT:
            begin
                // new process lands at the hole's place, the rest moves down
                if (at_pos)
                begin
                    seg_next = cmd.new_seg;
                end
                else if (at_next)
                begin
                    seg_next = cmd.hole_seg;
                end
                else if (past_next)
                begin
                    seg_next = left_seg;
                end
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // whole arena as one hole in slot 0 at the list head
            seg_reg.valid <= (idx == '0);
            seg_reg.hole  <= (idx == '0);
            seg_reg.size  <= (idx == '0) ? 16'(bfsa_pkg::ARENA_BYTES) : 16'd0;
            seg_reg.start <= 16'd0;
            seg_reg.slot  <= '0;
        end
        else
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg = seg_reg;

endmodule

FILE: rtl/core/best_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps
// top level of the best-fit segment allocator: sequencer and chain of cells
// depends on bfsa_pkg and bfsa_cell

// The segment list lives in a ring of NODES cells, cell k holding the k-th
// segment in address order. A request first rotates the ring once around
// while the head cell is examined (smallest fitting hole for allocate, first
// process of equal size for free); then the update state applies the change,
// waiting on any output stall, and the unit returns to idle. Slots are never
// released, so a new slot is simply the current segment count. One request is
// handled at a time; the result register frees the output side from the input
// side.

module best_fit_segment_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] request_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] block_offset,
    output logic [5:0]  block_slot
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    bfsa_pkg::seg_t segs [bfsa_pkg::NODES];
    bfsa_pkg::cmd_t cmd;

    // request and scan bookkeeping
    logic                        func_reg;
    logic [15:0]                 req_reg;
    logic [bfsa_pkg::IDX_W-1:0]  cnt_reg;
    logic [bfsa_pkg::CNT_W-1:0]  count_reg;
    logic                        found_reg;
    logic [bfsa_pkg::IDX_W-1:0]  pos_reg;
    logic [15:0]                 bsize_reg;
    logic [15:0]                 bstart_reg;
    logic [bfsa_pkg::IDX_W-1:0]  bslot_reg;

    // result register
    logic                        out_valid_reg;
    logic [1:0]                  status_reg;
    logic [15:0]                 offset_reg;
    logic [5:0]                  slot_reg;
    logic [1:0]                  status_next;
    logic [15:0]                 offset_next;
    logic [5:0]                  slot_next;

    bfsa_pkg::seg_t head;
    logic           hit;
    logic           scan_last;
    logic           out_free;
    logic           is_exact;
    logic           table_full;

    // chain of cells closed into a ring on the right; cell 0 takes itself as left neighbor
    genvar k;
    generate
        for (k = 0; k < bfsa_pkg::NODES; k++)
        begin : g_cell
            bfsa_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (bfsa_pkg::IDX_W'(k)),
                .cmd       (cmd),
                .left_seg  (segs[(k == 0) ? 0 : k - 1]),
                .right_seg (segs[(k + 1) % bfsa_pkg::NODES]),
                .seg       (segs[k])
            );
        end
    endgenerate

    assign head       = segs[0];
    assign scan_last  = (cnt_reg == bfsa_pkg::IDX_W'(bfsa_pkg::NODES - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_exact   = (bsize_reg == req_reg);
    assign table_full = (count_reg == bfsa_pkg::CNT_W'(bfsa_pkg::NODES));

    // match test on the head cell during the rotation
    always_comb
    begin
        if (func_reg == bfsa_pkg::FUNC_ALLOC)
        begin
            hit = head.valid && head.hole && (req_reg != 16'd0) &&
                  (head.size >= req_reg) && (!found_reg || head.size < bsize_reg);
        end
        else
        begin
            hit = !found_reg && head.valid && !head.hole && (head.size == req_reg);
        end
    end

    // command to the chain
    always_comb
    begin
        cmd.op             = bfsa_pkg::OP_HOLD;
        cmd.pos            = pos_reg;
        cmd.new_seg.valid  = 1'b1;
        cmd.new_seg.hole   = 1'b0;
        cmd.new_seg.size   = req_reg;
        cmd.new_seg.start  = bstart_reg;
        cmd.new_seg.slot   = count_reg[bfsa_pkg::IDX_W-1:0];
        cmd.hole_seg.valid = 1'b1;
        cmd.hole_seg.hole  = 1'b1;
        cmd.hole_seg.size  = bsize_reg - req_reg;
        cmd.hole_seg.start = bstart_reg + req_reg;
        cmd.hole_seg.slot  = bslot_reg;
        if (state_reg == S_SCAN)
        begin
            cmd.op = bfsa_pkg::OP_ROT;
        end
        else if (state_reg == S_UPD && out_free && found_reg)
        begin
            if (func_reg == bfsa_pkg::FUNC_FREE)
            begin
                cmd.op = bfsa_pkg::OP_FREE;
            end
            else if (is_exact)
            begin
                cmd.op = bfsa_pkg::OP_EXACT;
            end
            else if (!table_full)
            begin
                cmd.op = bfsa_pkg::OP_SPLIT;
            end
        end
    end

    // result fields for the request in hand
    always_comb
    begin
        status_next = bfsa_pkg::ST_OK;
        offset_next = bstart_reg;
        slot_next   = 6'(bslot_reg);
        if (!found_reg)
        begin
            status_next = (func_reg == bfsa_pkg::FUNC_FREE) ? bfsa_pkg::ST_NO_BLOCK
                                                             : bfsa_pkg::ST_NO_FIT;
            offset_next = 16'd0;
            slot_next   = 6'd0;
        end
        else if (func_reg == bfsa_pkg::FUNC_ALLOC && !is_exact)
        begin
            if (table_full)
            begin
                status_next = bfsa_pkg::ST_FULL;
                offset_next = 16'd0;
                slot_next   = 6'd0;
            end
            else
            begin
                slot_next = 6'(count_reg[bfsa_pkg::IDX_W-1:0]);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= bfsa_pkg::CNT_W'(1);
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_UPD:
                begin
                    if (out_free && cmd.op == bfsa_pkg::OP_SPLIT)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            req_reg  <= request_size;
        end
        if (state_reg == S_SCAN && hit)
        begin
            pos_reg    <= cnt_reg;
            bsize_reg  <= head.size;
            bstart_reg <= head.start;
            bslot_reg  <= head.slot;
        end
        if (state_reg == S_UPD && out_free)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            slot_reg   <= slot_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_offset = offset_reg;
    assign block_slot   = slot_reg;

endmodule
